// File: src/crm_pkg.sv
// ----------------------------------------------------------------------------
// crm_pkg
// Shared types and constants of the channel resampler and mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package crm_pkg;

  localparam int PHASE_FRAC_BITS = 14;
  localparam int MAX_OUT         = 64;
  localparam int PHASE_W         = 21;
  localparam int CNT_W           = $clog2(MAX_OUT + 1);
  localparam int SAMPLE_W        = 32;
  localparam int GAIN_W          = 16;
  localparam int CFG_W           = 21;
  localparam int CFG_IDX_W       = 3;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = SAMPLE_W + 1;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;
  localparam logic [PHASE_W-1:0] STEP_MIN  = PHASE_W'(256);
  localparam logic [PHASE_W-1:0] STEP_MAX  = PHASE_W'(1048576);

  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_S8  = 3'd1,
    FMT_S16 = 3'd2,
    FMT_U16 = 3'd3,
    FMT_S32 = 3'd4
  } fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORMAT = 3'd0,
    CFG_STEREO = 3'd1,
    CFG_SWAP   = 3'd2,
    CFG_STEP   = 3'd3,
    CFG_INTERP = 3'd4,
    CFG_LGAIN  = 3'd5,
    CFG_RGAIN  = 3'd6
  } cfg_idx_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PREP   = 7'b0000010,
    S_ILEFT  = 7'b0000100,
    S_IRIGHT = 7'b0001000,
    S_GLEFT  = 7'b0010000,
    S_GRIGHT = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

// File: src/crm_convert.sv
// ----------------------------------------------------------------------------
// crm_convert
// Converts one raw source word to a signed 32-bit sample by format.
// ----------------------------------------------------------------------------
`default_nettype none

module crm_convert (
  input  wire logic [31:0]                      raw,
  input  wire logic [2:0]                       format,
  input  wire logic                             swap,
  output logic signed [crm_pkg::SAMPLE_W-1:0]   sample
);

  logic [7:0]  byte_u;
  logic [7:0]  byte_s;
  logic [15:0] w16;
  logic [31:0] w32;

  always_comb begin
    byte_u = raw[7:0] ^ 8'h80;
    byte_s = raw[7:0];
    w16    = swap ? {raw[7:0], raw[15:8]} : raw[15:0];
    w32    = swap ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
    case (format)
      crm_pkg::FMT_U8:  sample = {{16{byte_u[7]}}, byte_u, 8'h00};
      crm_pkg::FMT_S8:  sample = {{16{byte_s[7]}}, byte_s, 8'h00};
      crm_pkg::FMT_S16: sample = {{16{w16[15]}}, w16};
      // Subtracting the midpoint is the same as flipping the top bit.
      crm_pkg::FMT_U16: sample = {{16{~w16[15]}}, ~w16[15], w16[14:0]};
      crm_pkg::FMT_S32: sample = w32;
      default:          sample = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: src/crm_mul.sv
// ----------------------------------------------------------------------------
// crm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module crm_mul (
  input  wire logic                                clk,
  input  wire logic                                load,
  input  wire logic signed [crm_pkg::MUL_A_W-1:0]  a,
  input  wire logic signed [crm_pkg::MUL_B_W-1:0]  b,
  output logic signed [crm_pkg::MUL_P_W-1:0]       prod
);

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= a * b;
    end
  end

endmodule

`default_nettype wire

// File: src/channel_resampler_mixer.sv
// ----------------------------------------------------------------------------
// channel_resampler_mixer
// Converts source frames, steps a phase accumulator and emits gain-scaled,
// held or linearly interpolated output words through one shared multiplier.
// ----------------------------------------------------------------------------
// Sequence: a frame is taken while idle. Each word then passes through PREP,
// ILEFT and IRIGHT when interpolating (IRIGHT in stereo only), GLEFT, GRIGHT and
// EMIT, where it waits while the mix side stalls; the steps run one after another
// through the one shared multiplier. No new frame is taken until the run ends,
// and a frame that makes no word leaves the block idle. Reset: synchronous;
// registers return to their defaults, phase to one step, history to zero.
`default_nettype none

module channel_resampler_mixer (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write,
  input  wire logic [crm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [crm_pkg::CFG_W-1:0]          cfg_data,
  input  wire logic                               src_valid,
  output logic                                    src_stall,
  input  wire logic [31:0]                        left_raw,
  input  wire logic [31:0]                        right_raw,
  output logic                                    mix_valid,
  input  wire logic                               mix_stall,
  output logic signed [31:0]                      left_mix,
  output logic signed [31:0]                      right_mix,
  output logic                                    last_of_run
);

  localparam int PW = crm_pkg::PHASE_W;
  localparam int SW = crm_pkg::SAMPLE_W;

  crm_pkg::state_t state;

  logic [2:0]          sample_format;
  logic                stereo_mode;
  logic                swap_bytes;
  logic [PW-1:0]       step_ratio;
  logic                interpolate_enable;
  logic [crm_pkg::GAIN_W-1:0] left_gain;
  logic [crm_pkg::GAIN_W-1:0] right_gain;

  logic [PW-1:0]             phase;
  logic [crm_pkg::CNT_W-1:0] count;
  logic signed [SW-1:0]      prev_left;
  logic signed [SW-1:0]      prev_right;
  logic signed [SW-1:0]      next_left;
  logic signed [SW-1:0]      next_right;
  logic signed [SW-1:0]      smp_left;
  logic signed [SW-1:0]      smp_right;
  logic [31:0]               mix_hold;

  logic signed [SW-1:0] conv_left;
  logic signed [SW-1:0] conv_right;

  logic                                    mul_load;
  logic signed [crm_pkg::MUL_A_W-1:0]      mul_a;
  logic signed [crm_pkg::MUL_B_W-1:0]      mul_b;
  logic signed [crm_pkg::MUL_P_W-1:0]      prod;
  logic signed [crm_pkg::MUL_P_W-1:0]      prod_shr;

  logic [PW-1:0] step_eff;
  logic [PW-1:0] phase_adj;
  logic [PW-1:0] phase_sum;
  logic          cap_hit;
  logic          is_last;
  logic          out_free;
  logic          src_take;
  logic signed [SW-1:0] interp_left;
  logic signed [SW-1:0] interp_right;

  crm_convert u_conv_left (
    .raw    (left_raw),
    .format (sample_format),
    .swap   (swap_bytes),
    .sample (conv_left)
  );

  crm_convert u_conv_right (
    .raw    (right_raw),
    .format (sample_format),
    .swap   (swap_bytes),
    .sample (conv_right)
  );

  crm_mul u_mul (
    .clk  (clk),
    .load (mul_load),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign src_stall = (state != crm_pkg::S_IDLE);
  assign src_take  = src_valid && !src_stall;
  assign out_free  = !mix_valid || !mix_stall;

  always_comb begin
    if (step_ratio < crm_pkg::STEP_MIN) begin
      step_eff = crm_pkg::STEP_MIN;
    end else if (step_ratio > crm_pkg::STEP_MAX) begin
      step_eff = crm_pkg::STEP_MAX;
    end else begin
      step_eff = step_ratio;
    end
    phase_adj = (phase >= crm_pkg::PHASE_ONE) ? phase - crm_pkg::PHASE_ONE : phase;
    phase_sum = phase + step_eff;
    cap_hit   = (count == crm_pkg::CNT_W'(crm_pkg::MAX_OUT - 1));
    is_last   = (phase_sum >= crm_pkg::PHASE_ONE) || cap_hit;
    // The arithmetic shift rounds toward minus infinity; the sum wraps
    // safely because the true result lies between the two samples.
    prod_shr     = prod >>> crm_pkg::PHASE_FRAC_BITS;
    interp_left  = prev_left + prod_shr[SW-1:0];
    interp_right = prev_right + prod_shr[SW-1:0];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      crm_pkg::S_PREP: begin
        mul_load = interpolate_enable;
        mul_a    = {next_left[SW-1], next_left} - {prev_left[SW-1], prev_left};
        mul_b    = crm_pkg::MUL_B_W'(phase[crm_pkg::PHASE_FRAC_BITS-1:0]);
      end
      crm_pkg::S_ILEFT: begin
        mul_load = stereo_mode;
        mul_a    = {next_right[SW-1], next_right} - {prev_right[SW-1], prev_right};
        mul_b    = crm_pkg::MUL_B_W'(phase[crm_pkg::PHASE_FRAC_BITS-1:0]);
      end
      crm_pkg::S_GLEFT: begin
        mul_load = 1'b1;
        mul_a    = {smp_left[SW-1], smp_left};
        mul_b    = {1'b0, left_gain};
      end
      crm_pkg::S_GRIGHT: begin
        mul_load = 1'b1;
        mul_a    = {smp_right[SW-1], smp_right};
        mul_b    = {1'b0, right_gain};
      end
      crm_pkg::S_IDLE, crm_pkg::S_IRIGHT, crm_pkg::S_EMIT: begin
        mul_load = 1'b0;
      end
      default: begin
        mul_load = 1'b0;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format      <= crm_pkg::FMT_S16;
      stereo_mode        <= 1'b0;
      swap_bytes         <= 1'b0;
      step_ratio         <= crm_pkg::PHASE_ONE;
      interpolate_enable <= 1'b0;
      left_gain          <= crm_pkg::GAIN_W'(8192);
      right_gain         <= crm_pkg::GAIN_W'(8192);
    end else if (cfg_write) begin
      unique case (cfg_index)
        crm_pkg::CFG_FORMAT: sample_format      <= cfg_data[2:0];
        crm_pkg::CFG_STEREO: stereo_mode        <= cfg_data[0];
        crm_pkg::CFG_SWAP:   swap_bytes         <= cfg_data[0];
        crm_pkg::CFG_STEP:   step_ratio         <= cfg_data[PW-1:0];
        crm_pkg::CFG_INTERP: interpolate_enable <= cfg_data[0];
        crm_pkg::CFG_LGAIN:  left_gain          <= cfg_data[crm_pkg::GAIN_W-1:0];
        crm_pkg::CFG_RGAIN:  right_gain         <= cfg_data[crm_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // The output word is marked valid when loaded and cleared once it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (state == crm_pkg::S_EMIT && out_free) begin
      mix_valid <= 1'b1;
    end else if (!mix_stall) begin
      mix_valid <= 1'b0;
    end
  end

  // Sequencer and sample history.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= crm_pkg::S_IDLE;
      phase      <= crm_pkg::PHASE_ONE;
      count      <= '0;
      prev_left  <= '0;
      prev_right <= '0;
      next_left  <= '0;
      next_right <= '0;
    end else begin
      unique case (state)
        crm_pkg::S_IDLE: begin
          if (src_take) begin
            phase <= phase_adj;
            count <= '0;
            if (phase >= crm_pkg::PHASE_ONE) begin
              prev_left <= next_left;
              next_left <= conv_left;
              if (stereo_mode) begin
                prev_right <= next_right;
                next_right <= conv_right;
              end
            end
            if (phase_adj < crm_pkg::PHASE_ONE) begin
              state <= crm_pkg::S_PREP;
            end
          end
        end
        crm_pkg::S_PREP: begin
          smp_left  <= prev_left;
          smp_right <= stereo_mode ? prev_right : prev_left;
          state     <= interpolate_enable ? crm_pkg::S_ILEFT : crm_pkg::S_GLEFT;
        end
        crm_pkg::S_ILEFT: begin
          smp_left <= interp_left;
          if (stereo_mode) begin
            state <= crm_pkg::S_IRIGHT;
          end else begin
            smp_right <= interp_left;
            state     <= crm_pkg::S_GLEFT;
          end
        end
        crm_pkg::S_IRIGHT: begin
          smp_right <= interp_right;
          state     <= crm_pkg::S_GLEFT;
        end
        crm_pkg::S_GLEFT: begin
          state <= crm_pkg::S_GRIGHT;
        end
        crm_pkg::S_GRIGHT: begin
          mix_hold <= prod[31:0];
          state    <= crm_pkg::S_EMIT;
        end
        crm_pkg::S_EMIT: begin
          if (out_free) begin
            left_mix    <= mix_hold;
            right_mix   <= prod[31:0];
            last_of_run <= is_last;
            count       <= count + 1'b1;
            // A capped run parks the phase at one whole step.
            if (cap_hit && phase_sum < crm_pkg::PHASE_ONE) begin
              phase <= crm_pkg::PHASE_ONE;
            end else begin
              phase <= phase_sum;
            end
            state <= is_last ? crm_pkg::S_IDLE : crm_pkg::S_PREP;
          end
        end
        default: begin
          state <= crm_pkg::S_IDLE;
        end
      endcase
    end
  end

  // While waiting for a frame, the phase always holds at least one whole step.
  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    (state == crm_pkg::S_IDLE) |-> (phase >= crm_pkg::PHASE_ONE))
    else $error("idle with phase below one step");

  // During a run the phase stays below one step.
  a_run_phase: assert property (@(posedge clk) disable iff (rst)
    (state != crm_pkg::S_IDLE) |-> (phase < crm_pkg::PHASE_ONE))
    else $error("run active with phase at or above one step");

  // The word count never passes the per-frame cap.
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (state != crm_pkg::S_IDLE) |-> (count < crm_pkg::CNT_W'(crm_pkg::MAX_OUT)))
    else $error("word count beyond cap");

  // In mono both channels scale the same sample.
  a_mono_same: assert property (@(posedge clk) disable iff (rst)
    (state == crm_pkg::S_GRIGHT && !stereo_mode) |-> (smp_right == smp_left))
    else $error("mono right sample differs from left");

  // A word loaded at the cap is flagged as the last of its frame.
  a_cap_last: assert property (@(posedge clk) disable iff (rst)
    (state == crm_pkg::S_EMIT && out_free && cap_hit) |=> last_of_run)
    else $error("capped word not marked last");

endmodule

`default_nettype wire

// File: bench/tb_channel_resampler_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_channel_resampler_mixer
// Self-checking bench for the channel resampler and mixer. Source frames go in
// with random gaps while the mix side stalls at random. A bit-exact predictor
// of format conversion, phase stepping, interpolation and gain keeps a queue
// of expected mix words, and every accepted word is checked field by field.
// ----------------------------------------------------------------------------

module tb_channel_resampler_mixer;
  import crm_pkg::*;

  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 24;
  localparam int REPORT_LIMIT  = 100;
  localparam logic [2:0] FMT_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]  fmt;
    logic        stereo;
    logic        swap;
    logic [20:0] step;
    logic        interp;
    logic [15:0] lgain;
    logic [15:0] rgain;
  } mixer_cfg_t;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
    logic        last;
  } mix_word_t;

  typedef struct packed {
    logic [2:0]  fmt;
    logic        swap;
    logic [31:0] left;
    logic [31:0] right;
  } format_case_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 src_valid = 1'b0;
  logic                 src_stall;
  logic [31:0]          left_raw = '0;
  logic [31:0]          right_raw = '0;
  logic                 mix_valid;
  logic                 mix_stall = 1'b0;
  logic signed [31:0]   left_mix;
  logic signed [31:0]   right_mix;
  logic                 last_of_run;

  // Predictor copy of the registers and the resampler state.
  mixer_cfg_t         cfg = '{fmt: FMT_S16, stereo: 1'b0, swap: 1'b0, step: 21'd16384,
                              interp: 1'b0, lgain: 16'd8192, rgain: 16'd8192};
  logic [PHASE_W-1:0] phase = PHASE_ONE;
  logic [31:0]        prev_l = '0;
  logic [31:0]        prev_r = '0;
  logic [31:0]        next_l = '0;
  logic [31:0]        next_r = '0;

  mix_word_t pending_mix[$];
  int        words_due = 0;
  int        mismatches = 0;
  int        cycle_count = 0;
  bit        src_idle_on = 1'b1;
  bit        mix_idle_on = 1'b1;
  int        hold_left = 0;
  int        stall_left = 0;

  channel_resampler_mixer dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .src_valid   (src_valid),
    .src_stall   (src_stall),
    .left_raw    (left_raw),
    .right_raw   (right_raw),
    .mix_valid   (mix_valid),
    .mix_stall   (mix_stall),
    .left_mix    (left_mix),
    .right_mix   (right_mix),
    .last_of_run (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
  endfunction

  function automatic logic [31:0] convert_raw(input logic [31:0] raw);
    logic [15:0] w16;
    logic [31:0] w32;
    longint      s;
    w16 = cfg.swap ? {raw[7:0], raw[15:8]} : raw[15:0];
    w32 = cfg.swap ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
    case (cfg.fmt)
      FMT_U8:  s = longint'($signed(raw[7:0] ^ 8'h80)) <<< 8;
      FMT_S8:  s = longint'($signed(raw[7:0])) <<< 8;
      FMT_S16: s = longint'($signed(w16));
      FMT_U16: s = longint'({1'b0, w16}) - longint'(32768);
      FMT_S32: s = longint'($signed(w32));
      default: s = 0;
    endcase
    return s[31:0];
  endfunction

  function automatic longint pick_sample(input logic [31:0] prev, input logic [31:0] next,
                                         input logic [PHASE_FRAC_BITS-1:0] frac);
    longint p;
    longint d;
    longint prod;
    p = longint'($signed(prev));
    if (!cfg.interp) return p;
    d = longint'($signed(next)) - p;
    prod = d * longint'({1'b0, frac});
    // Arithmetic shift floors toward minus infinity.
    return p + (prod >>> PHASE_FRAC_BITS);
  endfunction

  function automatic logic [31:0] apply_gain(input longint sample, input logic [15:0] gain);
    longint g;
    longint prod;
    g = longint'(gain);
    prod = sample * g;
    return prod[31:0];
  endfunction

  task automatic resample_frame(input logic [31:0] lraw, input logic [31:0] rraw);
    logic [PHASE_W-1:0] step;
    int                 n;
    longint             ls;
    longint             rs;
    mix_word_t          w;
    step = cfg.step;
    if (step < STEP_MIN) step = STEP_MIN;
    if (step > STEP_MAX) step = STEP_MAX;
    n = 0;
    if (phase >= PHASE_ONE) begin
      phase = phase - PHASE_ONE;
      prev_l = next_l;
      next_l = convert_raw(lraw);
      if (cfg.stereo) begin
        prev_r = next_r;
        next_r = convert_raw(rraw);
      end
    end
    while (phase < PHASE_ONE) begin
      if (n >= MAX_OUT) begin
        phase = PHASE_ONE;
        break;
      end
      ls = pick_sample(prev_l, next_l, phase[PHASE_FRAC_BITS-1:0]);
      rs = cfg.stereo ? pick_sample(prev_r, next_r, phase[PHASE_FRAC_BITS-1:0]) : ls;
      w.left = apply_gain(ls, cfg.lgain);
      w.right = apply_gain(rs, cfg.rgain);
      phase = phase + step;
      n++;
      // The run ends when the phase reaches one or the word cap is hit.
      w.last = (phase >= PHASE_ONE) || (n >= MAX_OUT);
      pending_mix.push_back(w);
    end
    words_due += n;
  endtask

  task automatic send_frame(input logic [31:0] l, input logic [31:0] r);
    int gap;
    src_valid <= 1'b1;
    left_raw <= l;
    right_raw <= r;
    do @(posedge clk); while (src_stall);
    resample_frame(l, r);
    gap = src_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every expected word is out and the block has gone quiet.
  task automatic settle();
    src_valid <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_mixer(input mixer_cfg_t c, input bit junk);
    cfg_idx_t         idx;
    logic [CFG_W-1:0] data;
    int               w;
    idx = idx.first();
    cfg_write <= 1'b1;
    repeat (idx.num()) begin
      case (idx)
        CFG_FORMAT: begin data = CFG_W'(c.fmt);    w = 3;  end
        CFG_STEREO: begin data = CFG_W'(c.stereo); w = 1;  end
        CFG_SWAP:   begin data = CFG_W'(c.swap);   w = 1;  end
        CFG_STEP:   begin data = CFG_W'(c.step);   w = 21; end
        CFG_INTERP: begin data = CFG_W'(c.interp); w = 1;  end
        CFG_LGAIN:  begin data = CFG_W'(c.lgain);  w = 16; end
        default:    begin data = CFG_W'(c.rgain);  w = 16; end
      endcase
      if (junk && w < CFG_W) data = data | (CFG_W'($urandom()) << w);
      cfg_index <= idx;
      cfg_data <= data;
      @(posedge clk);
      idx = idx.next();
    end
    cfg_write <= 1'b0;
    cfg = c;
  endtask

  function automatic mixer_cfg_t random_settings();
    mixer_cfg_t c;
    int         r;
    c.fmt = ($urandom_range(0, 5) != 0) ? 3'($urandom_range(FMT_U8, FMT_S32)) : 3'($urandom());
    c.stereo = 1'($urandom());
    c.swap = 1'($urandom());
    c.interp = 1'($urandom());
    r = $urandom_range(0, 19);
    if (r < 12) c.step = 21'($urandom_range(4096, 40000));
    else if (r < 17) c.step = 21'($urandom_range(STEP_MIN, 4095));
    else c.step = 21'($urandom_range(0, STEP_MIN - 1));
    r = $urandom_range(0, 9);
    c.lgain = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom());
    r = $urandom_range(0, 9);
    c.rgain = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom());
    return c;
  endfunction

  // Mix side: random stalls, none when a test turns them off, or a long hold when a test asks for one.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      mix_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (!mix_idle_on) begin
      mix_stall <= 1'b0;
    end else begin
      if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        mix_stall <= 1'b1;
        stall_left = stall_left - 1;
      end else begin
        mix_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_mix
    mix_word_t want;
    if (!rst && mix_valid && !mix_stall) begin
      if (pending_mix.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected mix word, expected none, actual %h %h %b",
                   $time, left_mix, right_mix, last_of_run);
      end else begin
        want = pending_mix.pop_front();
        if (left_mix !== want.left) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: left_mix expected %h actual %h", $time, want.left, left_mix);
        end
        if (right_mix !== want.right) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: right_mix expected %h actual %h", $time, want.right, right_mix);
        end
        if (last_of_run !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: last_of_run expected %b actual %b", $time, want.last, last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_channel_resampler_mixer NOT OK");
      $finish;
    end
  end

  // Registers untouched: signed 16-bit mono, unit step, hold, a gain of 8192 on both channels.
  task automatic test_reset_defaults();
    send_frame(32'h0000_7FFF, $urandom());
    send_frame(32'hFFFF_8000, $urandom());
    send_frame($urandom(), $urandom());
    settle();
  endtask

  task automatic test_formats();
    format_case_t cases[9];
    mixer_cfg_t   c;
    cases[0] = '{FMT_U8,     1'b1, 32'hA5A5_A500, 32'h0000_00FF};
    cases[1] = '{FMT_S8,     1'b1, 32'h0000_0080, 32'hFFFF_FF7F};
    cases[2] = '{FMT_S16,    1'b0, 32'hFFFF_8000, 32'h0000_7FFF};
    cases[3] = '{FMT_S16,    1'b1, 32'h1234_0080, 32'hABCD_FF7F};
    cases[4] = '{FMT_U16,    1'b0, 32'h0000_0000, 32'hFFFF_FFFF};
    cases[5] = '{FMT_U16,    1'b1, 32'h0000_0080, 32'h5555_3412};
    cases[6] = '{FMT_S32,    1'b0, 32'h8000_0000, 32'h7FFF_FFFF};
    cases[7] = '{FMT_S32,    1'b1, 32'h0000_0080, 32'hFFFF_FF7F};
    cases[8] = '{FMT_UNUSED, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000};
    // Half steps with interpolation show the old sample and the midpoint toward the new one.
    c = '{fmt: FMT_S16, stereo: 1'b1, swap: 1'b0, step: 21'd8192, interp: 1'b1,
          lgain: 16'hFFFF, rgain: 16'h0001};
    foreach (cases[i]) begin
      c.fmt = cases[i].fmt;
      c.swap = cases[i].swap;
      program_mixer(c, 1'b0);
      send_frame(cases[i].left, cases[i].right);
      settle();
    end
  endtask

  task automatic test_mono_interp();
    mixer_cfg_t c;
    c = '{fmt: FMT_S16, stereo: 1'b0, swap: 1'b0, step: 21'd12000, interp: 1'b1,
          lgain: 16'h2000, rgain: 16'h7FFF};
    program_mixer(c, 1'b0);
    send_frame(32'h0000_7FFF, $urandom());
    send_frame(32'h0000_8000, $urandom());
    send_frame(32'h0000_7FFF, $urandom());
    send_frame($urandom(), $urandom());
    settle();
  endtask

  task automatic test_step_extremes();
    mixer_cfg_t c;
    // A zero step is clamped to the minimum, which gives the full run of words.
    c = '{fmt: FMT_S32, stereo: 1'b1, swap: 1'b0, step: 21'd0, interp: 1'b1,
          lgain: 16'hFFFF, rgain: 16'hFFFF};
    program_mixer(c, 1'b0);
    send_frame(32'h7FFF_FFFF, 32'h8000_0000);
    send_frame(32'h8000_0000, 32'h7FFF_FFFF);
    settle();
    // Steps above one skip frames that make no word at all.
    c = '{fmt: FMT_S16, stereo: 1'b0, swap: 1'b0, step: 21'd20000, interp: 1'b0,
          lgain: 16'h0000, rgain: 16'hFFFF};
    program_mixer(c, 1'b0);
    repeat (3) send_frame($urandom(), $urandom());
    settle();
  endtask

  task automatic test_backpressure();
    mixer_cfg_t c;
    c = '{fmt: FMT_S16, stereo: 1'b1, swap: 1'b1, step: 21'd8192, interp: 1'b1,
          lgain: 16'd8192, rgain: 16'd8192};
    program_mixer(c, 1'b0);
    src_idle_on = 1'b0;
    hold_left = 400;
    repeat (10) send_frame($urandom(), $urandom());
    settle();
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_settings();
    mixer_cfg_t c;
    int         p;
    int         n;
    int         start;
    p = 0;
    start = words_due;
    while (p < 6 || words_due - start < 32) begin
      c = random_settings();
      n = $urandom_range(2, 5);
      src_idle_on = ($urandom_range(0, 3) != 0);
      mix_idle_on = ($urandom_range(0, 3) != 0);
      if (p == 0) begin
        // Above the maximum step: only one frame in 64 makes a word.
        c.step = 21'($urandom_range(STEP_MAX + 1, 2 ** PHASE_W - 1));
        n = 66;
      end else if (p == 1) begin
        src_idle_on = 1'b0;
        mix_idle_on = 1'b0;
      end
      program_mixer(c, 1'($urandom_range(0, 1)));
      repeat (n) send_frame($urandom(), $urandom());
      settle();
      p++;
    end
    src_idle_on = 1'b1;
    mix_idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_formats();
    test_mono_interp();
    test_step_extremes();
    test_backpressure();
    test_random_settings();
    settle();
    if (mismatches == 0) begin
      $display("tb_channel_resampler_mixer OK");
    end else begin
      $display("tb_channel_resampler_mixer NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
src/crm_pkg.sv
src/crm_convert.sv
src/crm_mul.sv
src/channel_resampler_mixer.sv
bench/tb_channel_resampler_mixer.sv
